### sv/plm_pkg.sv
// Package for the piecewise linear membership block.
// Register index codes and fixed field widths; no dependencies.
package plm_pkg;

	// Width of the configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	// Fixed width of one packed breakpoint byte and of the I/O fields
	localparam int BYTE_W = 8;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TRUNC_LEFT  = 3'd0,
		REG_TRUNC_RIGHT = 3'd1,
		REG_POINT_COUNT = 3'd2,
		REG_X_POINTS    = 3'd3,
		REG_Y_POINTS    = 3'd4
	} cfg_reg_t;

	// Reset value of the point count
	localparam logic [3:0] POINT_COUNT_RST = 4'd2;

endpackage

### sv/piecewise_linear_membership.sv
// Piecewise linear membership: breakpoint search, multiply and pipelined divider.
// Depends on plm_pkg.
//
// Usage:
// - Configuration: wr_en, wr_index, wr_data. Index 0 trunc_left, 1 trunc_right,
//   2 point_count, 3 x_points, 4 y_points; other indexes are ignored. Write only
//   while no request is in flight.
// - Requests: crisp_value is taken at a clock edge with start high and busy low.
//   busy is always low; a new request may come in every cycle.
// - Results: membership is valid for exactly one cycle while done is high.
// - Throughput is one request per cycle. The depth of the pipeline is set by the
//   restoring divider, which resolves one quotient bit per pipeline stage, behind
//   three stages for breakpoint compare, segment select and multiply, plus the
//   output register.
// - Results leave in request order; the receiver cannot stall the pipeline.
// - Reset (arst_n low) clears all valid bits and puts the registers at their
//   reset values: no truncation, two points, all breakpoints zero.
module piecewise_linear_membership
	import plm_pkg::*;
#(
	parameter int MAX_POINTS = 8,
	parameter int VALUE_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	input  logic                  start,
	output logic                  busy,
	input  logic [BYTE_W-1:0]     crisp_value,
	output logic                  done,
	output logic [BYTE_W-1:0]     membership
);

	localparam int VB    = VALUE_BITS;
	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int LAT   = VB + 4;
	localparam logic [VB-1:0] VAL_MAX = {VB{1'b1}};

	// Configuration registers
	logic                  trunc_left_q;
	logic                  trunc_right_q;
	logic [3:0]            point_count_q;
	logic [CFG_DATA_W-1:0] x_points_q;
	logic [CFG_DATA_W-1:0] y_points_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trunc_left_q  <= 1'b0;
			trunc_right_q <= 1'b0;
			point_count_q <= POINT_COUNT_RST;
			x_points_q    <= '0;
			y_points_q    <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_TRUNC_LEFT:  trunc_left_q  <= wr_data[0];
				REG_TRUNC_RIGHT: trunc_right_q <= wr_data[0];
				REG_POINT_COUNT: point_count_q <= wr_data[3:0];
				REG_X_POINTS:    x_points_q    <= wr_data;
				REG_Y_POINTS:    y_points_q    <= wr_data;
				default: ;
			endcase
		end
	end

	// Breakpoints unpacked to VALUE_BITS wide entries
	logic [VB-1:0] bx [MAX_POINTS];
	logic [VB-1:0] by [MAX_POINTS];
	logic [IDX_W-1:0] last_idx;

	always_comb begin
		for (int k = 0; k < MAX_POINTS; k++) begin
			bx[k] = x_points_q[BYTE_W*k +: VB];
			by[k] = y_points_q[BYTE_W*k +: VB];
		end
		if (point_count_q < 4'd2) begin
			last_idx = IDX_W'(1);
		end else if (point_count_q > 4'(MAX_POINTS)) begin
			last_idx = IDX_W'(MAX_POINTS - 1);
		end else begin
			last_idx = IDX_W'(point_count_q - 4'd1);
		end
	end

	// Never holds requests off: the pipeline advances every cycle
	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// Stage 1: compare the input against every breakpoint
	logic                  v_s1;
	logic [VB-1:0]         r_s1;
	logic [MAX_POINTS-1:0] le_s1;
	logic                  below_s1;
	logic                  above_s1;
	logic [VB-1:0]         r_in;
	logic [MAX_POINTS-1:0] le_in;

	assign r_in = crisp_value[VB-1:0];

	always_comb begin
		le_in = '0;
		for (int k = 1; k < MAX_POINTS; k++) begin
			le_in[k] = (r_in <= bx[k]) && (IDX_W'(k) <= last_idx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		r_s1     <= r_in;
		le_s1    <= le_in;
		below_s1 <= r_in < bx[0];
		above_s1 <= r_in > bx[last_idx];
	end

	// Stage 2: pick the segment, set up the interpolation terms
	logic          v_s2;
	logic          spec_s2;
	logic [VB-1:0] spec_val_s2;
	logic [VB-1:0] a_s2;
	logic [VB-1:0] dx_s2;
	logic [VB-1:0] dy_mag_s2;
	logic          dy_neg_s2;
	logic [VB-1:0] y0_s2;

	logic [IDX_W-1:0] sel;
	logic             found;
	logic [VB-1:0]    x0, x1, y0, y1;
	logic [VB-1:0]    dx;
	logic             spec;
	logic [VB-1:0]    spec_val;

	always_comb begin
		sel   = IDX_W'(1);
		found = 1'b0;
		for (int k = MAX_POINTS - 1; k >= 1; k--) begin
			if (le_s1[k]) begin
				sel   = IDX_W'(k);
				found = 1'b1;
			end
		end
		x0 = bx[IDX_W'(sel - 1'b1)];
		y0 = by[IDX_W'(sel - 1'b1)];
		x1 = bx[sel];
		y1 = by[sel];
		dx = x1 - x0;
		// outside ranges, no bracket and a zero-width segment bypass the divider
		spec     = 1'b1;
		spec_val = '0;
		if (below_s1) begin
			spec_val = trunc_left_q ? '0 : by[0];
		end else if (above_s1) begin
			spec_val = trunc_right_q ? '0 : by[last_idx];
		end else if (!found) begin
			spec_val = '0;
		end else if (dx == '0) begin
			spec_val = y1;
		end else begin
			spec = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		spec_s2     <= spec;
		spec_val_s2 <= spec_val;
		a_s2        <= r_s1 - x0;
		dx_s2       <= dx;
		dy_neg_s2   <= y1 < y0;
		dy_mag_s2   <= (y1 < y0) ? (y0 - y1) : (y1 - y0);
		y0_s2       <= y0;
	end

	// Stage 3: product of offset and rise magnitude
	logic            v_s3;
	logic            spec_s3;
	logic [VB-1:0]   spec_val_s3;
	logic [2*VB-1:0] prod_s3;
	logic [VB-1:0]   dx_s3;
	logic            dy_neg_s3;
	logic [VB-1:0]   y0_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		spec_s3     <= spec_s2;
		spec_val_s3 <= spec_val_s2;
		prod_s3     <= a_s2 * dy_mag_s2;
		dx_s3       <= dx_s2;
		dy_neg_s3   <= dy_neg_s2;
		y0_s3       <= y0_s2;
	end

	// Divider: entry k of each array is pipeline stage 4+k, one quotient bit each.
	// The offset never exceeds the run, so the quotient fits in VALUE_BITS bits.
	logic          dv_v_s4        [VB];
	logic          dv_spec_s4     [VB];
	logic [VB-1:0] dv_spec_val_s4 [VB];
	logic [VB-1:0] dv_rem_s4      [VB];
	logic [VB-1:0] dv_low_s4      [VB];
	logic [VB-1:0] dv_q_s4        [VB];
	logic [VB-1:0] dv_dx_s4       [VB];
	logic          dv_neg_s4      [VB];
	logic [VB-1:0] dv_y0_s4       [VB];

	for (genvar k = 0; k < VB; k++) begin : g_div
		logic          v_in, spec_in, neg_in;
		logic [VB-1:0] spec_val_in, rem_in, low_in, q_in, dx_in, y0_in;
		logic [VB:0]   trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign v_in        = v_s3;
			assign spec_in     = spec_s3;
			assign spec_val_in = spec_val_s3;
			assign rem_in      = prod_s3[2*VB-1:VB];
			assign low_in      = prod_s3[VB-1:0];
			assign q_in        = '0;
			assign dx_in       = dx_s3;
			assign neg_in      = dy_neg_s3;
			assign y0_in       = y0_s3;
		end else begin : g_next
			assign v_in        = dv_v_s4[k-1];
			assign spec_in     = dv_spec_s4[k-1];
			assign spec_val_in = dv_spec_val_s4[k-1];
			assign rem_in      = dv_rem_s4[k-1];
			assign low_in      = dv_low_s4[k-1];
			assign q_in        = dv_q_s4[k-1];
			assign dx_in       = dv_dx_s4[k-1];
			assign neg_in      = dv_neg_s4[k-1];
			assign y0_in       = dv_y0_s4[k-1];
		end

		// restoring step: shift in the next dividend bit, subtract if it fits
		assign trial = {rem_in, low_in[VB-1]};
		assign ge    = trial >= {1'b0, dx_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s4[k] <= 1'b0;
			end else begin
				dv_v_s4[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			dv_spec_s4[k]     <= spec_in;
			dv_spec_val_s4[k] <= spec_val_in;
			dv_rem_s4[k]      <= ge ? VB'(trial - {1'b0, dx_in}) : trial[VB-1:0];
			dv_low_s4[k]      <= {low_in[VB-2:0], 1'b0};
			dv_q_s4[k]        <= {q_in[VB-2:0], ge};
			dv_dx_s4[k]       <= dx_in;
			dv_neg_s4[k]      <= neg_in;
			dv_y0_s4[k]       <= y0_in;
		end
	end

	// Output stage: apply the quotient with its sign, saturate
	logic            done_q;
	logic [VB-1:0]   mem_q;
	logic signed [VB+1:0] sum;
	logic [VB-1:0]   interp;

	always_comb begin
		if (dv_neg_s4[VB-1]) begin
			sum = $signed({2'b00, dv_y0_s4[VB-1]}) - $signed({2'b00, dv_q_s4[VB-1]});
		end else begin
			sum = $signed({2'b00, dv_y0_s4[VB-1]}) + $signed({2'b00, dv_q_s4[VB-1]});
		end
		if (sum < 0) begin
			interp = '0;
		end else if (sum > $signed({2'b00, VAL_MAX})) begin
			interp = VAL_MAX;
		end else begin
			interp = sum[VB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_v_s4[VB-1];
		end
	end

	always_ff @(posedge clk) begin
		mem_q <= dv_spec_s4[VB-1] ? dv_spec_val_s4[VB-1] : interp;
	end

	assign done       = done_q;
	assign membership = BYTE_W'(mem_q);

	// Checks
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a request LAT cycles earlier");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !spec_s2 |-> dx_s2 != '0)
		else $error("divider entered with zero run");

	a_offset_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !spec_s2 |-> a_s2 <= dx_s2)
		else $error("offset beyond segment run");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dv_v_s4[VB-1] && !dv_spec_s4[VB-1] |-> dv_rem_s4[VB-1] < dv_dx_s4[VB-1])
		else $error("divider remainder not below divisor");

endmodule

### verif/testbench.sv
// Self-checking testbench for piecewise_linear_membership.
// Drives directed and random crisp values under changing breakpoint setups and checks
// each result against a typed-in value or an interpolation predictor. Needs plm_pkg.
module testbench
	import plm_pkg::*;
();

	localparam int MAX_PTS      = 8;
	localparam int PIPE_LATENCY = 8 + 4;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int RAND_PHASES  = 12;
	localparam int PHASE_ITEMS  = 125;
	localparam int DIR_ROWS_N   = 23;

	// First index past the defined registers; writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] UNUSED_REG = REG_Y_POINTS + 3'd1;

	// One complete breakpoint setup
	typedef struct packed {
		logic        tl;
		logic        tr;
		logic [3:0]  count;
		logic [63:0] xs;
		logic [63:0] ys;
	} bp_setup_t;

	// Directed row: setup to use, crisp value, and a typed-in result when known
	typedef struct packed {
		logic [1:0] setup;
		logic [7:0] crisp;
		logic       known;
		logic [7:0] membership;
	} stim_row_t;

	// Request waiting for its membership result
	typedef struct packed {
		logic [7:0] crisp;
		logic [7:0] membership;
	} pending_t;

	localparam stim_row_t DIR_ROWS [DIR_ROWS_N] = '{
		// reset setup: both x at zero, all y zero
		'{2'd0, 8'd0,   1'b1, 8'd0},
		'{2'd0, 8'd255, 1'b1, 8'd0},
		'{2'd0, 8'd128, 1'b1, 8'd0},
		// both truncations on, four points with a repeated x
		'{2'd1, 8'd0,   1'b1, 8'd0},
		'{2'd1, 8'd9,   1'b1, 8'd0},
		'{2'd1, 8'd255, 1'b1, 8'd0},
		'{2'd1, 8'd201, 1'b1, 8'd0},
		'{2'd1, 8'd10,  1'b0, 8'd0},
		'{2'd1, 8'd35,  1'b0, 8'd0},
		'{2'd1, 8'd60,  1'b0, 8'd0},
		'{2'd1, 8'd61,  1'b0, 8'd0},
		'{2'd1, 8'd200, 1'b0, 8'd0},
		// count of zero acts as two; equal x gives the second y
		'{2'd2, 8'd0,   1'b1, 8'd5},
		'{2'd2, 8'd29,  1'b1, 8'd5},
		'{2'd2, 8'd30,  1'b1, 8'd77},
		'{2'd2, 8'd31,  1'b1, 8'd77},
		'{2'd2, 8'd255, 1'b1, 8'd77},
		// count above the maximum, x not ascending
		'{2'd3, 8'd0,   1'b0, 8'd0},
		'{2'd3, 8'd50,  1'b0, 8'd0},
		'{2'd3, 8'd100, 1'b0, 8'd0},
		'{2'd3, 8'd101, 1'b0, 8'd0},
		'{2'd3, 8'd254, 1'b0, 8'd0},
		'{2'd3, 8'd255, 1'b0, 8'd0}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;
	logic                  start;
	logic                  busy;
	logic [BYTE_W-1:0]     crisp_value;
	logic                  done;
	logic [BYTE_W-1:0]     membership;

	// Predictor copy of the registers
	logic        cfg_tl;
	logic        cfg_tr;
	logic [3:0]  cfg_count;
	logic [63:0] cfg_x;
	logic [63:0] cfg_y;

	pending_t pending_q [$];
	int       err_count;
	int       cycle_count;

	piecewise_linear_membership dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.start       (start),
		.busy        (busy),
		.crisp_value (crisp_value),
		.done        (done),
		.membership  (membership)
	);

	// Clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Run limit
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0d: %s", cycle_count, msg);
		err_count++;
	endtask

	// Breakpoint count after clamping to 2..MAX_PTS
	function automatic int active_points();
		int n;
		n = int'(cfg_count);
		if (n < 2)
			n = 2;
		if (n > MAX_PTS)
			n = MAX_PTS;
		return n;
	endfunction

	// Expected membership of one crisp value under the current setup
	function automatic logic [7:0] predict_membership(input logic [7:0] crisp);
		int r, n, last, i, x0, x1, y0, y1, dx, v;
		r    = int'(crisp);
		n    = active_points();
		last = n - 1;
		if (r < int'(cfg_x[7:0]))
			return cfg_tl ? 8'd0 : cfg_y[7:0];
		if (r > int'(cfg_x[8*last +: 8]))
			return cfg_tr ? 8'd0 : cfg_y[8*last +: 8];
		for (i = 1; i < n; i++) begin
			x1 = int'(cfg_x[8*i +: 8]);
			if (r <= x1) begin
				x0 = int'(cfg_x[8*(i-1) +: 8]);
				y0 = int'(cfg_y[8*(i-1) +: 8]);
				y1 = int'(cfg_y[8*i +: 8]);
				dx = x1 - x0;
				if (dx == 0)
					return y1[7:0];
				// quotient truncates toward zero, then saturate
				v = y0 + ((r - x0) * (y1 - y0)) / dx;
				if (v < 0)
					return 8'd0;
				if (v > 255)
					return 8'd255;
				return v[7:0];
			end
		end
		return 8'd0;
	endfunction

	// Random crisp value: uniform, the extremes, or close to a breakpoint
	function automatic logic [7:0] pick_crisp();
		int sel, k, t;
		sel = $urandom_range(0, 9);
		if (sel < 6)
			return 8'($urandom_range(0, 255));
		if (sel == 6)
			return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
		k = $urandom_range(0, active_points() - 1);
		t = int'(cfg_x[8*k +: 8]) + int'($urandom_range(0, 2)) - 1;
		if (t < 0)
			t = 0;
		if (t > 255)
			t = 255;
		return t[7:0];
	endfunction

	// Random setup: mostly ascending x, some repeated x, some unordered
	function automatic bp_setup_t random_setup();
		bp_setup_t  s;
		logic [7:0] b [8];
		logic [7:0] t;
		int         i, j, mode;
		s.tl = 1'($urandom_range(0, 1));
		s.tr = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 4) == 0)
			s.count = 4'($urandom_range(0, 15));
		else
			s.count = 4'($urandom_range(2, 8));
		for (i = 0; i < 8; i++)
			b[i] = 8'($urandom_range(0, 255));
		mode = $urandom_range(0, 9);
		if (mode < 8) begin
			for (i = 0; i < 7; i++)
				for (j = 0; j < 7 - i; j++)
					if (b[j] > b[j+1]) begin
						t      = b[j];
						b[j]   = b[j+1];
						b[j+1] = t;
					end
			if (mode >= 6) begin
				j    = $urandom_range(1, 7);
				b[j] = b[j-1];
			end
		end
		for (i = 0; i < 8; i++)
			s.xs[8*i +: 8] = b[i];
		s.ys = {$urandom, $urandom};
		return s;
	endfunction

	// One register write; the predictor copy follows it
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
		case (idx)
			REG_TRUNC_LEFT:  cfg_tl    = data[0];
			REG_TRUNC_RIGHT: cfg_tr    = data[0];
			REG_POINT_COUNT: cfg_count = data[3:0];
			REG_X_POINTS:    cfg_x     = data;
			REG_Y_POINTS:    cfg_y     = data;
			default: ;
		endcase
	endtask

	// Load a whole setup; unused data bits carry random values
	task automatic apply_setup(input bp_setup_t s, input bit poke_unused);
		logic [63:0] d;
		d      = {$urandom, $urandom};
		d[0]   = s.tl;
		write_reg(REG_TRUNC_LEFT, d);
		d      = {$urandom, $urandom};
		d[0]   = s.tr;
		write_reg(REG_TRUNC_RIGHT, d);
		d      = {$urandom, $urandom};
		d[3:0] = s.count;
		write_reg(REG_POINT_COUNT, d);
		write_reg(REG_X_POINTS, s.xs);
		write_reg(REG_Y_POINTS, s.ys);
		if (poke_unused)
			write_reg(UNUSED_REG, {$urandom, $urandom});
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// Issue one request after a random gap; queue its expected result
	task automatic push_request(input logic [7:0] v, input logic [7:0] e, input int idle_pct);
		while ($urandom_range(1, 100) <= idle_pct) begin
			@(negedge clk);
			start       <= 1'b0;
			crisp_value <= 8'($urandom_range(0, 255));
		end
		@(negedge clk);
		start       <= 1'b1;
		crisp_value <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_q.push_back('{crisp: v, membership: e});
	endtask

	// Stop requesting and wait for every outstanding result
	task automatic wait_drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
	endtask

	// Result checker
	always @(posedge clk) begin
		pending_t p;
		if (arst_n && done) begin
			if (pending_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result %0d", membership));
			end else begin
				p = pending_q.pop_front();
				if (membership !== p.membership)
					report_mismatch($sformatf("crisp %0d: membership %0d, expected %0d",
						p.crisp, membership, p.membership));
			end
		end
	end

	// Stimulus
	initial begin
		bp_setup_t  dir_setups [4];
		bp_setup_t  s;
		stim_row_t  row;
		logic [7:0] v;
		logic [7:0] e;
		int         cur_setup, phase, k, idle_pct;
		int         idle_tbl [4];

		idle_tbl    = '{0, 57, 0, 27};
		err_count   = 0;
		arst_n      = 1'b0;
		wr_en       = 1'b0;
		wr_index    = '0;
		wr_data     = '0;
		start       = 1'b0;
		crisp_value = '0;
		cfg_tl      = 1'b0;
		cfg_tr      = 1'b0;
		cfg_count   = POINT_COUNT_RST;
		cfg_x       = '0;
		cfg_y       = '0;

		dir_setups[0] = {1'b0, 1'b0, POINT_COUNT_RST, 64'h0, 64'h0};
		dir_setups[1] = {1'b1, 1'b1, 4'd4, 64'hFFFF_FFFF_C83C_3C0A, 64'h0000_0000_FFFA_6428};
		dir_setups[2] = {1'b0, 1'b0, 4'd0, 64'h0000_0000_0000_1E1E, 64'h0000_0000_0000_4D05};
		dir_setups[3] = {1'b0, 1'b1, 4'd15, 64'hFF5A_503C_2814_6400, 64'h80C8_1E14_0A00_FF00};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part; the reset setup is used as is
		cur_setup = 0;
		for (k = 0; k < DIR_ROWS_N; k++) begin
			row = DIR_ROWS[k];
			if (int'(row.setup) != cur_setup) begin
				wait_drain();
				cur_setup = int'(row.setup);
				apply_setup(dir_setups[cur_setup], 1'b0);
			end
			e = row.known ? row.membership : predict_membership(row.crisp);
			push_request(row.crisp, e, 0);
		end

		// Random phases: extremes first, then random setups
		for (phase = 0; phase < RAND_PHASES; phase++) begin
			wait_drain();
			if (phase == 0) begin
				s = {1'b1, 1'b1, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};
			end else if (phase == 1) begin
				s = {1'b0, 1'b0, 4'd2, 64'hFFFF_FFFF_FFFF_FF00, 64'h0000_0000_0000_FF00};
			end else begin
				s = random_setup();
			end
			apply_setup(s, (phase % 3) == 2);
			idle_pct = idle_tbl[phase % 4];
			for (k = 0; k < PHASE_ITEMS; k++) begin
				// occasional full pause until the pipeline is empty
				if ($urandom_range(0, 99) == 0)
					wait_drain();
				v = pick_crisp();
				push_request(v, predict_membership(v), idle_pct);
			end
		end

		wait_drain();
		repeat (PIPE_LATENCY + 4) @(posedge clk);
		if (err_count == 0 && pending_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
